// ----- src/jsd_pkg.sv -----
// Package for the JSON string decoder: word types, state codes and the UTF-8 encoder.
`timescale 1ns / 1ps

package jsd_pkg;

    localparam int MAX_STRING_BYTES_DEF = 64;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_BODY    = 3'd1,
        PH_ESC     = 3'd2,
        PH_HEX1    = 3'd3,
        PH_WANT_BS = 3'd4,
        PH_WANT_U  = 3'd5,
        PH_HEX2    = 3'd6,
        PH_UTF8    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_BAD   = 2'd2,
        ST_NOSTR = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] status;
        logic [7:0] decoded_length;
        logic       truncated;
        logic       last_of_item;
    } out_word_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] hex_acc;
        logic [1:0]  hex_cnt;
        logic [9:0]  hi_sur;
        logic [7:0]  lead;
        logic [15:0] pend;
        logic [1:0]  needed;
        logic [1:0]  seen;
        logic [7:0]  len;
        logic        ovf;
    } jsd_state_t;

    // All results caused by one input word, delivered one per cycle while m_ready is high.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            byte_valid;
        status_t         status;
        logic [7:0]      len0;
        logic            ov0;
    } jsd_bundle_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } utf8_enc_t;

    function automatic utf8_enc_t utf8_encode(input logic [20:0] cp);
        utf8_enc_t e;
        e.bytes = '0;
        if (cp <= 21'h7f) begin
            e.bytes[0] = {1'b0, cp[6:0]};
            e.count = 3'd1;
        end else if (cp <= 21'h7ff) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count = 3'd2;
        end else if (cp <= 21'hffff) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count = 3'd4;
        end
        return e;
    endfunction

endpackage

// ----- src/jsd_decoder.sv -----
// Next-state and result logic for one input word of the JSON string decoder.
`timescale 1ns / 1ps

module jsd_decoder #(
    parameter int MAX_STRING_BYTES = jsd_pkg::MAX_STRING_BYTES_DEF
) (
    input  jsd_pkg::jsd_state_t  state_cur,
    input  jsd_pkg::in_word_t    word,
    output jsd_pkg::jsd_state_t  state_nx,
    output jsd_pkg::jsd_bundle_t bundle
);

    localparam logic [9:0] MAX_W = 10'(MAX_STRING_BYTES);

    localparam logic [7:0] CH_LOW_B = 8'h62;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_N = 8'h6e;
    localparam logic [7:0] CH_LOW_R = 8'h72;
    localparam logic [7:0] CH_LOW_T = 8'h74;

    logic [7:0]          c;
    logic [3:0]          nib;
    logic                nib_ok;
    logic [15:0]         hex_v;
    logic [20:0]         cp;
    logic                do_cp;
    jsd_pkg::utf8_enc_t  enc;
    logic [2:0]          n;
    logic [3:0][7:0]     bytes;
    jsd_pkg::status_t    st;
    logic [7:0]          base_len;
    logic                base_ov;
    logic [7:0]          lo;
    logic [7:0]          hi;
    logic [9:0]          sum;

    assign c     = word.in_byte;
    assign hex_v = {state_cur.hex_acc[11:0], nib};
    assign enc   = jsd_pkg::utf8_encode(cp);

    always_comb begin
        nib    = 4'd0;
        nib_ok = 1'b1;
        if (c inside {[8'h30:8'h39]}) begin
            nib = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            nib = c[3:0] + 4'd9;
        end else begin
            nib_ok = 1'b0;
        end
    end

    always_comb begin
        lo = 8'h80;
        hi = 8'hbf;
        if (state_cur.seen == 2'd0) begin
            case (state_cur.lead)
                8'he0:   lo = 8'ha0;
                8'hed:   hi = 8'h9f;
                8'hf0:   lo = 8'h90;
                8'hf4:   hi = 8'h8f;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_nx = state_cur;
        st       = jsd_pkg::ST_BUSY;
        n        = 3'd0;
        bytes    = '0;
        cp       = '0;
        do_cp    = 1'b0;
        base_len = state_cur.len;
        base_ov  = state_cur.ovf;

        if (state_cur.phase == jsd_pkg::PH_IDLE) begin
            base_len = 8'd0;
            base_ov  = 1'b0;
            state_nx.len = 8'd0;
            state_nx.ovf = 1'b0;
            if (!word.end_of_input && c == jsd_pkg::CH_QUOTE) begin
                state_nx.phase = jsd_pkg::PH_BODY;
            end else begin
                st = jsd_pkg::ST_NOSTR;
            end
        end else if (word.end_of_input) begin
            st = jsd_pkg::ST_BAD;
        end else begin
            case (state_cur.phase)
                jsd_pkg::PH_BODY: begin
                    if (c == jsd_pkg::CH_QUOTE) begin
                        state_nx.phase = jsd_pkg::PH_IDLE;
                        st = jsd_pkg::ST_DONE;
                    end else if (c == jsd_pkg::CH_BSLASH) begin
                        state_nx.phase = jsd_pkg::PH_ESC;
                    end else if (c < 8'h20) begin
                        st = jsd_pkg::ST_BAD;
                    end else if (c < 8'h80) begin
                        n = 3'd1;
                        bytes[0] = c;
                    end else if (c inside {[8'hc2:8'hf4]}) begin
                        if (c inside {[8'hc2:8'hdf]}) begin
                            state_nx.needed = 2'd1;
                        end else if (c inside {[8'he0:8'hef]}) begin
                            state_nx.needed = 2'd2;
                        end else begin
                            state_nx.needed = 2'd3;
                        end
                        state_nx.lead  = c;
                        state_nx.pend  = '0;
                        state_nx.seen  = 2'd0;
                        state_nx.phase = jsd_pkg::PH_UTF8;
                    end else begin
                        st = jsd_pkg::ST_BAD;
                    end
                end
                jsd_pkg::PH_ESC: begin
                    state_nx.phase = jsd_pkg::PH_BODY;
                    n = 3'd1;
                    case (c)
                        jsd_pkg::CH_QUOTE, jsd_pkg::CH_BSLASH, jsd_pkg::CH_SLASH: bytes[0] = c;
                        CH_LOW_B: bytes[0] = 8'h08;
                        CH_LOW_F: bytes[0] = 8'h0c;
                        CH_LOW_N: bytes[0] = 8'h0a;
                        CH_LOW_R: bytes[0] = 8'h0d;
                        CH_LOW_T: bytes[0] = 8'h09;
                        jsd_pkg::CH_LOW_U: begin
                            n = 3'd0;
                            state_nx.hex_acc = '0;
                            state_nx.hex_cnt = 2'd0;
                            state_nx.phase   = jsd_pkg::PH_HEX1;
                        end
                        default: st = jsd_pkg::ST_BAD;
                    endcase
                end
                jsd_pkg::PH_HEX1, jsd_pkg::PH_HEX2: begin
                    if (!nib_ok) begin
                        st = jsd_pkg::ST_BAD;
                    end else begin
                        state_nx.hex_acc = hex_v;
                        state_nx.hex_cnt = state_cur.hex_cnt + 2'd1;
                        if (state_cur.hex_cnt == 2'd3) begin
                            if (state_cur.phase == jsd_pkg::PH_HEX2) begin
                                if (hex_v inside {[16'hdc00:16'hdfff]}) begin
                                    cp = 21'h10000 + {1'b0, state_cur.hi_sur, hex_v[9:0]};
                                    do_cp = 1'b1;
                                    state_nx.phase = jsd_pkg::PH_BODY;
                                end else begin
                                    st = jsd_pkg::ST_BAD;
                                end
                            end else if (hex_v inside {[16'hd800:16'hdbff]}) begin
                                state_nx.hi_sur = hex_v[9:0];
                                state_nx.phase  = jsd_pkg::PH_WANT_BS;
                            end else if (hex_v inside {[16'hdc00:16'hdfff]}) begin
                                st = jsd_pkg::ST_BAD;
                            end else begin
                                cp = {5'd0, hex_v};
                                do_cp = 1'b1;
                                state_nx.phase = jsd_pkg::PH_BODY;
                            end
                        end
                    end
                end
                jsd_pkg::PH_WANT_BS: begin
                    if (c == jsd_pkg::CH_BSLASH) begin
                        state_nx.phase = jsd_pkg::PH_WANT_U;
                    end else begin
                        st = jsd_pkg::ST_BAD;
                    end
                end
                jsd_pkg::PH_WANT_U: begin
                    if (c == jsd_pkg::CH_LOW_U) begin
                        state_nx.hex_acc = '0;
                        state_nx.hex_cnt = 2'd0;
                        state_nx.phase   = jsd_pkg::PH_HEX2;
                    end else begin
                        st = jsd_pkg::ST_BAD;
                    end
                end
                jsd_pkg::PH_UTF8: begin
                    if (c < lo || c > hi) begin
                        st = jsd_pkg::ST_BAD;
                    end else if ({1'b0, state_cur.seen} + 3'd1 >= {1'b0, state_cur.needed}) begin
                        // sequence complete: release lead, held bytes and this one
                        bytes[0] = state_cur.lead;
                        case (state_cur.seen)
                            2'd0: begin
                                bytes[1] = c;
                                n = 3'd2;
                            end
                            2'd1: begin
                                bytes[1] = state_cur.pend[7:0];
                                bytes[2] = c;
                                n = 3'd3;
                            end
                            default: begin
                                bytes[1] = state_cur.pend[7:0];
                                bytes[2] = state_cur.pend[15:8];
                                bytes[3] = c;
                                n = 3'd4;
                            end
                        endcase
                        state_nx.seen  = 2'd0;
                        state_nx.pend  = '0;
                        state_nx.phase = jsd_pkg::PH_BODY;
                    end else begin
                        if (state_cur.seen[0]) begin
                            state_nx.pend[15:8] = state_cur.pend[15:8] | c;
                        end else begin
                            state_nx.pend[7:0] = state_cur.pend[7:0] | c;
                        end
                        state_nx.seen = state_cur.seen + 2'd1;
                    end
                end
                default: st = jsd_pkg::ST_BAD;
            endcase
        end

        if (do_cp) begin
            n     = enc.count;
            bytes = enc.bytes;
        end

        // drop everything a malformed word produced
        if (st == jsd_pkg::ST_BAD) begin
            n = 3'd0;
            state_nx.phase = jsd_pkg::PH_IDLE;
        end

        sum = {2'b00, base_len} + {7'd0, n};
        if (n != 3'd0) begin
            state_nx.len = (sum > 10'd255) ? 8'hff : sum[7:0];
            state_nx.ovf = base_ov | ((sum - 10'd1) >= MAX_W);
        end

        bundle.bytes      = bytes;
        bundle.byte_valid = (n != 3'd0);
        bundle.last_idx   = (n != 3'd0) ? 2'(n - 3'd1) : 2'd0;
        bundle.status     = st;
        bundle.len0       = base_len;
        bundle.ov0        = base_ov;
    end

endmodule

// ----- src/json_string_decoder_unit.sv -----
// Top level of the JSON string decoder: input register, decode, result serializer.
`timescale 1ns / 1ps

// JSON string decoder.
// The s_ channel takes one word per text byte, starting with the opening
// quote; end_of_input set marks the end of the text and carries no byte.
// The m_ channel gives 1 to 4 result words per input word: decoded UTF-8
// bytes with the running length, truncation flag and status, last_of_item
// set on the final one. A word that decodes to no byte gives one result
// with byte_valid clear carrying the status.
// Path: an accepted word waits in the input register until the result
// register is free, is then decoded into it, and its first result is on m_;
// further results of the same word follow one per cycle while m_ready is
// high. Throughput: one input word per cycle while each decodes to at most
// one byte and m_ready is high, as the result register delivers one result
// a cycle; a word of more bytes holds it until its last result is taken.
// Reset (aresetn low, synchronous) empties both registers and returns the
// decoder to waiting for an opening quote.
// When m_ready is low the result register holds, the input register takes
// one more word, and s_ready then falls until results drain.

module json_string_decoder_unit #(
    parameter int MAX_STRING_BYTES = jsd_pkg::MAX_STRING_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jsd_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jsd_pkg::out_word_t  m_data
);

    localparam logic [9:0] MAX_W = 10'(MAX_STRING_BYTES);

    jsd_pkg::in_word_t    in_word_reg;
    logic                 in_valid_reg;
    jsd_pkg::jsd_state_t  state_reg;
    jsd_pkg::jsd_state_t  state_next;
    jsd_pkg::jsd_bundle_t bun_reg;
    jsd_pkg::jsd_bundle_t bun_next;
    logic                 bun_valid_reg;
    logic [1:0]           idx_reg;

    logic                 out_take;
    logic                 out_last;
    logic                 load;
    logic [9:0]           sum_k;
    logic [9:0]           sum_k1;

    jsd_decoder #(
        .MAX_STRING_BYTES(MAX_STRING_BYTES)
    ) u_dec (
        .state_cur(state_reg),
        .word     (in_word_reg),
        .state_nx (state_next),
        .bundle   (bun_next)
    );

    assign out_last = (idx_reg == bun_reg.last_idx);
    assign out_take = bun_valid_reg && m_ready;
    assign load     = in_valid_reg && (!bun_valid_reg || (out_take && out_last));
    assign s_ready  = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            bun_valid_reg       <= 1'b0;
            idx_reg             <= 2'd0;
            state_reg           <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (load) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                state_reg     <= state_next;
                bun_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end else if (out_take) begin
                // advance through the word's results, free the register on the last
                if (out_last) begin
                    bun_valid_reg <= 1'b0;
                end else begin
                    idx_reg <= idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
        if (load) begin
            bun_reg <= bun_next;
        end
    end

    assign sum_k  = {2'b00, bun_reg.len0} + {8'd0, idx_reg};
    assign sum_k1 = sum_k + 10'd1;

    always_comb begin
        m_valid               = bun_valid_reg;
        m_data.byte_valid     = bun_reg.byte_valid;
        m_data.status         = bun_reg.status;
        m_data.last_of_item   = out_last;
        if (bun_reg.byte_valid) begin
            m_data.out_byte       = bun_reg.bytes[idx_reg];
            m_data.decoded_length = (sum_k1 > 10'd255) ? 8'hff : sum_k1[7:0];
            m_data.truncated      = bun_reg.ov0 | (sum_k >= MAX_W);
        end else begin
            m_data.out_byte       = 8'd0;
            m_data.decoded_length = bun_reg.len0;
            m_data.truncated      = bun_reg.ov0;
        end
    end

endmodule

// ----- src/jsd_checker.sv -----
// Port-level checks for the JSON string decoder and their bind to the top level.
`timescale 1ns / 1ps

module jsd_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input jsd_pkg::out_word_t m_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.byte_valid |-> m_data.last_of_item && m_data.out_byte == 8'd0)
        else $error("empty result word not marked last or carries a byte");

    a_final_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != jsd_pkg::ST_BUSY
            |-> m_data.last_of_item && !m_data.byte_valid)
        else $error("terminal status on a word carrying a byte");

    a_run_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_of_item
            |=> m_valid && m_data.byte_valid
                && m_data.decoded_length == (($past(m_data.decoded_length) == 8'hff)
                    ? 8'hff : $past(m_data.decoded_length) + 8'd1))
        else $error("results of one word not back to back with counted length");

endmodule

bind json_string_decoder_unit jsd_checker u_jsd_checker (.*);

// ----- verif/tb_json_string_decoder_unit.sv -----
// Testbench for json_string_decoder_unit: directed table, random strings, scoreboard.
`timescale 1ns / 1ps

module tb_json_string_decoder_unit;

    localparam int MAX_BYTES      = jsd_pkg::MAX_STRING_BYTES_DEF;
    localparam int NUM_DIRECTED   = 29;
    localparam int RANDOM_WORDS   = 150;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_WAIT       = 16;

    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;

    typedef struct packed {
        jsd_pkg::in_word_t  word;
        logic               typed;
        jsd_pkg::out_word_t want;
    } stim_t;

    // Results that can be read straight off the input.
    localparam jsd_pkg::out_word_t NOSTR_IDLE =
        {8'h00, 1'b0, jsd_pkg::ST_NOSTR, 8'd0, 1'b0, 1'b1};
    localparam jsd_pkg::out_word_t OPENED     =
        {8'h00, 1'b0, jsd_pkg::ST_BUSY, 8'd0, 1'b0, 1'b1};
    localparam jsd_pkg::out_word_t BAD_EMPTY  =
        {8'h00, 1'b0, jsd_pkg::ST_BAD, 8'd0, 1'b0, 1'b1};
    localparam jsd_pkg::out_word_t BAD_ONE    =
        {8'h00, 1'b0, jsd_pkg::ST_BAD, 8'd1, 1'b0, 1'b1};
    localparam jsd_pkg::out_word_t PREDICTED  = '0;

    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    jsd_pkg::in_word_t  s_data  = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    jsd_pkg::out_word_t m_data;

    json_string_decoder_unit #(.MAX_STRING_BYTES(MAX_BYTES)) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // Decoder state mirrored by the predictor
    jsd_pkg::phase_t ph      = jsd_pkg::PH_IDLE;
    logic [15:0]     hex_acc = '0;
    logic [1:0]      hex_cnt = '0;
    logic [9:0]      hi_sur  = '0;
    logic [7:0]      lead    = '0;
    logic [23:0]     pend    = '0;
    logic [1:0]      needed  = '0;
    logic [1:0]      seen    = '0;
    logic [7:0]      dec_len = '0;
    logic            ovf     = 1'b0;

    logic [7:0] emit_b [4];
    logic [7:0] emit_l [4];
    logic       emit_t [4];
    int         n_emit;

    jsd_pkg::out_word_t decoded_q [$];
    jsd_pkg::in_word_t  text_q [$];
    stim_t              directed_tab [NUM_DIRECTED];

    int fails           = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int strings_built   = 0;
    int quiet_cycles    = 0;
    bit calm_tx         = 1'b0;
    bit calm_rx         = 1'b0;
    bit hold_rx         = 1'b0;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        if (n_emit < 4) begin
            if (dec_len >= MAX_BYTES) ovf = 1'b1;
            if (dec_len != 8'hff) dec_len = dec_len + 8'd1;
            emit_b[n_emit] = b;
            emit_l[n_emit] = dec_len;
            emit_t[n_emit] = ovf;
            n_emit++;
        end
    endtask

    task automatic emit_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            emit_byte({3'b110, cp[10:6]});
            emit_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            emit_byte({4'b1110, cp[15:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end else begin
            emit_byte({5'b11110, cp[20:18]});
            emit_byte({2'b10, cp[17:12]});
            emit_byte({2'b10, cp[11:6]});
            emit_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic hex_digit(input logic [7:0] c, input bit second,
                             output jsd_pkg::status_t st);
        int nib;
        nib = hex_value(c);
        st = jsd_pkg::ST_BUSY;
        if (nib < 0) begin
            st = jsd_pkg::ST_BAD;
        end else begin
            hex_acc = {hex_acc[11:0], nib[3:0]};
            if (hex_cnt != 2'd3) begin
                hex_cnt = hex_cnt + 2'd1;
            end else begin
                hex_cnt = 2'd0;
                if (second) begin
                    if (hex_acc < 16'hdc00 || hex_acc > 16'hdfff) begin
                        st = jsd_pkg::ST_BAD;
                    end else begin
                        emit_code_point({1'b0, hi_sur, hex_acc[9:0]} + 21'h10000);
                        ph = jsd_pkg::PH_BODY;
                    end
                end else if (hex_acc >= 16'hd800 && hex_acc <= 16'hdbff) begin
                    hi_sur = hex_acc[9:0];
                    ph = jsd_pkg::PH_WANT_BS;
                end else if (hex_acc >= 16'hdc00 && hex_acc <= 16'hdfff) begin
                    st = jsd_pkg::ST_BAD;
                end else begin
                    emit_code_point({5'b0, hex_acc});
                    ph = jsd_pkg::PH_BODY;
                end
            end
        end
    endtask

    // Advance the mirrored decoder by one input word and queue its results.
    task automatic decode_word(input jsd_pkg::in_word_t w);
        jsd_pkg::status_t   st;
        logic [7:0]         c;
        logic [7:0]         esc;
        logic [7:0]         lo;
        logic [7:0]         hi;
        logic [1:0]         need;
        jsd_pkg::out_word_t r;
        c = w.in_byte;
        st = jsd_pkg::ST_BUSY;
        n_emit = 0;
        if (ph == jsd_pkg::PH_IDLE) begin
            dec_len = '0;
            ovf = 1'b0;
            if (!w.end_of_input && c == jsd_pkg::CH_QUOTE) ph = jsd_pkg::PH_BODY;
            else st = jsd_pkg::ST_NOSTR;
        end else if (w.end_of_input) begin
            st = jsd_pkg::ST_BAD;
        end else begin
            case (ph)
                jsd_pkg::PH_BODY: begin
                    if (c == jsd_pkg::CH_QUOTE) begin
                        ph = jsd_pkg::PH_IDLE;
                        st = jsd_pkg::ST_DONE;
                    end else if (c == jsd_pkg::CH_BSLASH) begin
                        ph = jsd_pkg::PH_ESC;
                    end else if (c < 8'h20) begin
                        st = jsd_pkg::ST_BAD;
                    end else if (c < 8'h80) begin
                        emit_byte(c);
                    end else begin
                        need = 2'd0;
                        if (c >= 8'hc2 && c <= 8'hdf) need = 2'd1;
                        else if (c >= 8'he0 && c <= 8'hef) need = 2'd2;
                        else if (c >= 8'hf0 && c <= 8'hf4) need = 2'd3;
                        if (need == 2'd0) begin
                            st = jsd_pkg::ST_BAD;
                        end else begin
                            needed = need;
                            lead = c;
                            pend = '0;
                            seen = '0;
                            ph = jsd_pkg::PH_UTF8;
                        end
                    end
                end
                jsd_pkg::PH_ESC: begin
                    case (c)
                        jsd_pkg::CH_QUOTE, jsd_pkg::CH_BSLASH, jsd_pkg::CH_SLASH: esc = c;
                        CH_B:    esc = 8'h08;
                        CH_F:    esc = 8'h0c;
                        CH_N:    esc = 8'h0a;
                        CH_R:    esc = 8'h0d;
                        CH_T:    esc = 8'h09;
                        default: esc = 8'h00;
                    endcase
                    if (c == jsd_pkg::CH_LOW_U) begin
                        hex_acc = '0;
                        hex_cnt = '0;
                        ph = jsd_pkg::PH_HEX1;
                    end else if (esc == 8'h00) begin
                        st = jsd_pkg::ST_BAD;
                    end else begin
                        emit_byte(esc);
                        ph = jsd_pkg::PH_BODY;
                    end
                end
                jsd_pkg::PH_HEX1: hex_digit(c, 1'b0, st);
                jsd_pkg::PH_WANT_BS: begin
                    if (c == jsd_pkg::CH_BSLASH) ph = jsd_pkg::PH_WANT_U;
                    else st = jsd_pkg::ST_BAD;
                end
                jsd_pkg::PH_WANT_U: begin
                    if (c == jsd_pkg::CH_LOW_U) begin
                        hex_acc = '0;
                        hex_cnt = '0;
                        ph = jsd_pkg::PH_HEX2;
                    end else begin
                        st = jsd_pkg::ST_BAD;
                    end
                end
                jsd_pkg::PH_HEX2: hex_digit(c, 1'b1, st);
                jsd_pkg::PH_UTF8: begin
                    lo = 8'h80;
                    hi = 8'hbf;
                    // tighter second-byte window for overlong, surrogate and out-of-range leads
                    if (seen == 2'd0) begin
                        if (lead == 8'he0) lo = 8'ha0;
                        else if (lead == 8'hed) hi = 8'h9f;
                        else if (lead == 8'hf0) lo = 8'h90;
                        else if (lead == 8'hf4) hi = 8'h8f;
                    end
                    if (c < lo || c > hi) begin
                        st = jsd_pkg::ST_BAD;
                    end else if (int'(seen) + 1 >= int'(needed)) begin
                        emit_byte(lead);
                        if (seen >= 2'd1) emit_byte(pend[7:0]);
                        if (seen >= 2'd2) emit_byte(pend[15:8]);
                        emit_byte(c);
                        seen = '0;
                        pend = '0;
                        ph = jsd_pkg::PH_BODY;
                    end else begin
                        pend = pend | (24'(c) << (seen[0] ? 8 : 0));
                        seen = seen + 2'd1;
                    end
                end
                default: st = jsd_pkg::ST_BAD;
            endcase
        end
        if (st == jsd_pkg::ST_BAD) begin
            n_emit = 0;
            ph = jsd_pkg::PH_IDLE;
        end
        if (n_emit == 0) begin
            r = {8'h00, 1'b0, st, dec_len, ovf, 1'b1};
            decoded_q.push_back(r);
        end else begin
            for (int k = 0; k < n_emit; k++) begin
                r = {emit_b[k], 1'b1, st, emit_l[k], emit_t[k], k == n_emit - 1};
                decoded_q.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_result(input jsd_pkg::out_word_t got);
        jsd_pkg::out_word_t want;
        if (decoded_q.size() == 0) begin
            $error("result word %0h arrived with nothing pending", got);
            fails++;
        end else begin
            want = decoded_q.pop_front();
            check_field("out_byte", want.out_byte, got.out_byte);
            check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("decoded_length", want.decoded_length, got.decoded_length);
            check_field("truncated", 8'(want.truncated), 8'(got.truncated));
            check_field("last_of_item", 8'(want.last_of_item), 8'(got.last_of_item));
        end
        results_checked++;
    endtask

    // Offer one word; called and returning at a falling edge.
    task automatic send_word(input jsd_pkg::in_word_t w, input bit typed,
                             input jsd_pkg::out_word_t want);
        int gap;
        int n0;
        gap = calm_tx ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n0 = decoded_q.size();
        decode_word(w);
        if (typed) begin
            while (decoded_q.size() > n0) void'(decoded_q.pop_back());
            decoded_q.push_back(want);
        end
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(nib) - 8'd10;
    endfunction

    task automatic push_text(input logic [7:0] b);
        text_q.push_back({b, 1'b0});
    endtask

    task automatic push_hex4(input logic [15:0] v);
        for (int i = 3; i >= 0; i--) push_text(hex_char(v[4*i +: 4]));
    endtask

    task automatic push_utf8(input int n);
        logic [7:0] b;
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hbf;
        if (n == 2) begin
            b = 8'($urandom_range('hc2, 'hdf));
        end else if (n == 3) begin
            b = 8'($urandom_range('he0, 'hef));
            if (b == 8'he0) lo = 8'ha0;
            if (b == 8'hed) hi = 8'h9f;
        end else begin
            b = 8'($urandom_range('hf0, 'hf4));
            if (b == 8'hf0) lo = 8'h90;
            if (b == 8'hf4) hi = 8'h8f;
        end
        push_text(b);
        push_text(8'($urandom_range(lo, hi)));
        for (int i = 2; i < n; i++) push_text(8'($urandom_range('h80, 'hbf)));
    endtask

    task automatic push_token();
        int          r;
        int          flaw;
        logic [7:0]  b;
        logic [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            b = 8'($urandom_range('h20, 'h7f));
            if (b == jsd_pkg::CH_QUOTE || b == jsd_pkg::CH_BSLASH) b = 8'h41;
            push_text(b);
        end else if (r < 45) begin
            push_text(jsd_pkg::CH_BSLASH);
            case ($urandom_range(0, 7))
                0: push_text(jsd_pkg::CH_QUOTE);
                1: push_text(jsd_pkg::CH_BSLASH);
                2: push_text(jsd_pkg::CH_SLASH);
                3: push_text(CH_B);
                4: push_text(CH_F);
                5: push_text(CH_N);
                6: push_text(CH_R);
                default: push_text(CH_T);
            endcase
        end else if (r < 60) begin
            case ($urandom_range(0, 2))
                0: v = 16'($urandom_range(0, 'h7f));
                1: v = 16'($urandom_range('h80, 'h7ff));
                default: v = 16'($urandom_range('h800, 'hffff));
            endcase
            // move a surrogate value out of the surrogate block
            if (v[15:11] == 5'b11011) v[14] = 1'b0;
            push_text(jsd_pkg::CH_BSLASH);
            push_text(jsd_pkg::CH_LOW_U);
            push_hex4(v);
        end else if (r < 70) begin
            flaw = $urandom_range(0, 19);
            push_text(jsd_pkg::CH_BSLASH);
            push_text(jsd_pkg::CH_LOW_U);
            push_hex4(16'hd800 + 16'($urandom_range(0, 'h3ff)));
            push_text(flaw == 0 ? 8'h41 : jsd_pkg::CH_BSLASH);
            push_text(flaw == 1 ? 8'h78 : jsd_pkg::CH_LOW_U);
            if (flaw == 2) push_hex4(16'hd800 + 16'($urandom_range(0, 'h3ff)));
            else if (flaw == 3) push_hex4(16'($urandom_range(0, 'hd7ff)));
            else if (flaw == 4) push_text(8'h7a);
            else push_hex4(16'hdc00 + 16'($urandom_range(0, 'h3ff)));
        end else if (r < 94) begin
            push_utf8($urandom_range(2, 4));
        end else begin
            case ($urandom_range(0, 4))
                0: push_text(8'($urandom_range(0, 255)));
                1: begin
                    push_text(8'($urandom_range('hc2, 'hf4)));
                    push_text(8'($urandom_range(0, 255)));
                end
                2: begin
                    push_text(jsd_pkg::CH_BSLASH);
                    push_text(8'($urandom_range(0, 255)));
                end
                3: begin
                    push_text(jsd_pkg::CH_BSLASH);
                    push_text(jsd_pkg::CH_LOW_U);
                    push_text(hex_char(4'($urandom_range(0, 15))));
                    push_text(8'($urandom_range(0, 255)));
                end
                default: text_q.push_back({8'($urandom_range(0, 255)), 1'b1});
            endcase
        end
    endtask

    task automatic build_string(input int n_tokens);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2))
                text_q.push_back({8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))});
        end
        push_text(jsd_pkg::CH_QUOTE);
        repeat (n_tokens) push_token();
        case ($urandom_range(0, 9))
            0: text_q.push_back({8'($urandom_range(0, 255)), 1'b1});
            1: ;
            default: push_text(jsd_pkg::CH_QUOTE);
        endcase
        strings_built++;
    endtask

    task automatic send_text();
        while (text_q.size() != 0) send_word(text_q.pop_front(), 1'b0, PREDICTED);
    endtask

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : result_side
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_rx) begin
                // hold off long enough for the block to back up into s_ready
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_rx = 1'b0;
            end else begin
                stall = calm_rx ? 0 : $urandom_range(0, 12);
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_result(m_data);
            if (results_checked % 50 == 0) calm_rx = ($urandom_range(0, 3) == 0);
            @(negedge aclk);
        end
    end

    initial begin : text_side
        int random_words;
        directed_tab = '{
            {8'hff,              1'b0, 1'b1, NOSTR_IDLE},   // non-quote while waiting
            {8'h00,              1'b1, 1'b1, NOSTR_IDLE},   // end of input while waiting
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {8'h7f,              1'b0, 1'b0, PREDICTED},
            {jsd_pkg::CH_BSLASH, 1'b0, 1'b0, PREDICTED},
            {8'h78,              1'b0, 1'b1, BAD_ONE},      // unknown escape letter
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {jsd_pkg::CH_BSLASH, 1'b0, 1'b0, PREDICTED},
            {jsd_pkg::CH_LOW_U,  1'b0, 1'b0, PREDICTED},
            {8'h67,              1'b0, 1'b1, BAD_EMPTY},    // bad hex digit
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {jsd_pkg::CH_BSLASH, 1'b0, 1'b0, PREDICTED},
            {jsd_pkg::CH_LOW_U,  1'b0, 1'b0, PREDICTED},
            {8'h44,              1'b0, 1'b0, PREDICTED},
            {8'h43,              1'b0, 1'b0, PREDICTED},
            {8'h30,              1'b0, 1'b0, PREDICTED},
            {8'h30,              1'b0, 1'b1, BAD_EMPTY},    // lone low surrogate
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {8'hed,              1'b0, 1'b0, PREDICTED},
            {8'ha0,              1'b0, 1'b1, BAD_EMPTY},    // second byte out of bound
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {8'h1f,              1'b0, 1'b1, BAD_EMPTY},    // control byte
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {8'h00,              1'b1, 1'b1, BAD_EMPTY},    // input ends inside string
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {8'hc1,              1'b0, 1'b1, BAD_EMPTY},    // invalid lead
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b1, OPENED},
            {8'h20,              1'b0, 1'b0, PREDICTED},
            {jsd_pkg::CH_QUOTE,  1'b0, 1'b0, PREDICTED}
        };
        random_words = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_word(directed_tab[i].word, directed_tab[i].typed, directed_tab[i].want);
        drain_results();

        // long string of four-byte characters: truncation and length saturation,
        // sent while the result side holds off
        hold_rx = 1'b1;
        push_text(jsd_pkg::CH_QUOTE);
        repeat (66) push_utf8(4);
        push_text(jsd_pkg::CH_QUOTE);
        send_text();

        while (random_words < RANDOM_WORDS) begin
            calm_tx = ($urandom_range(0, 4) == 0);
            if (strings_built == 4) drain_results();
            build_string(($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(0, 12));
            random_words += text_q.size();
            send_text();
        end

        drain_results();
        repeat (END_WAIT) @(negedge aclk);
        if (decoded_q.size() != 0) begin
            $error("%0d decoded results never arrived", decoded_q.size());
            fails++;
        end
        $display("Sent %0d text words over %0d random strings plus the directed table;",
                 words_sent, strings_built);
        $display("checked %0d result words (escapes, \\u pairs, raw UTF-8, errors, saturation).",
                 results_checked);
        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- json_string_decoder_unit.f -----
src/jsd_pkg.sv
src/jsd_decoder.sv
src/json_string_decoder_unit.sv
src/jsd_checker.sv
verif/tb_json_string_decoder_unit.sv
